// ===== rtl/pcbse_pkg.sv =====
package pcbse_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_COEFFS_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed formats
  localparam int WBITS      = 28;
  localparam int FIFO_DEPTH = 16;
  localparam int SIZE_MIN   = 4;

  localparam logic [10:0] SIZE_RST = 11'd4;
  localparam logic [7:0]  MULT_RST = 8'd1;

  // Reciprocals for exact division by three
  localparam logic [17:0] DIV3_M18 = 18'd174763;
  localparam logic [19:0] DIV3_M20 = 20'd699051;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic {
    REG_SIZE = 1'b0,
    REG_MULT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [47:0] slope;
  } result_t;

  // floor(x / 3) for an 18-bit x
  function automatic logic [17:0] div3_18(input logic [17:0] x);
    logic [35:0] p;
    p = 36'(x) * 36'(DIV3_M18);
    return 18'(p[35:19]);
  endfunction

  // floor(x / 3) for a 20-bit x below 3 * 2^18
  function automatic logic [17:0] div3_20(input logic [19:0] x);
    logic [39:0] p;
    p = 40'(x) * 40'(DIV3_M20);
    return p[38:21];
  endfunction

endpackage

// ===== rtl/pcbse_coef_mem.sv =====
module pcbse_coef_mem #(
  parameter int DEPTH  = pcbse_pkg::MAX_COEFFS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr [4],
  output logic [31:0]       rd_data [4]
);

  // Two copies, each with two read ports; every load writes both
  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];

  // Write both copies and register the reads: copy A serves the two lower
  // neighbours, copy B the two upper ones
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    rd_data[0] <= mem_a[rd_addr[0]];
    rd_data[1] <= mem_a[rd_addr[1]];
    rd_data[2] <= mem_b[rd_addr[2]];
    rd_data[3] <= mem_b[rd_addr[3]];
  end

endmodule

// ===== rtl/pcbse_out_fifo.sv =====
module pcbse_out_fifo #(
  parameter int DEPTH = pcbse_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pcbse_pkg::result_t  wdata,
  output logic                valid,
  input  logic                stall,
  output pcbse_pkg::result_t  rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pcbse_pkg::result_t store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          pop;

  assign pop   = valid && !stall;
  assign valid = (count != '0);
  assign rdata = store[rd_ptr];

  // Work out the new fill level
  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  // Hold words
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < CW'(DEPTH)))
    else $error("output queue overflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("output queue count did not advance");
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && count == '0) |=> valid)
    else $error("pushed word not shown");
`endif

endmodule

// ===== rtl/periodic_cubic_bspline_eval_unit.sv =====
// A sample word passes the pipeline stages and the output queue before it is shown.
// Throughput: one item per cycle unless stalled; loads and samples may be back to back.
// Input stalls only while 16 samples are outstanding (pipeline plus output queue).
// The four neighbour coefficients are read together from two dual-read table copies.
// Reset clears pipeline valids, queue and configuration (size 4, multiplier 1);
// the coefficient table is not cleared and must be loaded before use.
module periodic_cubic_bspline_eval_unit #(
  parameter int MAX_COEFFS = pcbse_pkg::MAX_COEFFS_DEF,
  parameter int FRAC_BITS  = pcbse_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [9:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic [31:0]        phase,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] spline_value,
  output logic signed [47:0] spline_slope
);

  localparam int WB     = pcbse_pkg::WBITS;
  localparam int ADDR_W = $clog2(MAX_COEFFS);
  localparam int SIZE_W = $clog2(MAX_COEFFS + 1);
  localparam int CMP_W  = (SIZE_W > 11) ? SIZE_W : 11;
  localparam int IW     = ADDR_W + 2;
  localparam int LW     = ((ADDR_W > 10) ? ADDR_W : 10) + 1;
  localparam int S_W    = SIZE_W + 8;
  localparam int CNT_W  = $clog2(pcbse_pkg::FIFO_DEPTH + 1);
  localparam int HI_W   = 34;
  localparam int PH_W   = HI_W + S_W + 1;
  localparam int PL_W   = 29 + S_W;
  localparam int SL_W0  = HI_W + S_W + 2;
  localparam int SL_W   = (SL_W0 > 50) ? SL_W0 : 50;

  localparam logic [63:0] ACC_OFS = 64'h6000_0000_3000_0000;
  localparam logic signed [36:0] V_OFS = 37'sd4294967296;
  localparam logic signed [36:0] V_MAX = 37'sd2147483647;
  localparam logic signed [36:0] V_MIN = -37'sd2147483648;
  localparam logic signed [SL_W-1:0] SL_MAX = $signed((SL_W'(1) << 47) - SL_W'(1));
  localparam logic signed [SL_W-1:0] SL_MIN = $signed(~SL_W'(0) << 47);

  // Configuration
  logic [10:0]       size_cfg;
  logic [7:0]        mult_cfg;
  logic [SIZE_W-1:0] sz;
  logic [CMP_W-1:0]  size_ext;
  logic [S_W-1:0]    s_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= pcbse_pkg::SIZE_RST;
      mult_cfg <= pcbse_pkg::MULT_RST;
    end else if (cfg_write) begin
      unique case (pcbse_pkg::reg_idx_t'(cfg_index))
        pcbse_pkg::REG_SIZE: size_cfg <= cfg_data;
        pcbse_pkg::REG_MULT: mult_cfg <= cfg_data[7:0];
        default:             size_cfg <= size_cfg;
      endcase
    end
  end

  // Clamp the period into the table range
  always_comb begin
    size_ext = CMP_W'(size_cfg);
    if (size_ext < CMP_W'(pcbse_pkg::SIZE_MIN)) begin
      sz = SIZE_W'(pcbse_pkg::SIZE_MIN);
    end else if (size_ext > CMP_W'(MAX_COEFFS)) begin
      sz = SIZE_W'(MAX_COEFFS);
    end else begin
      sz = size_ext[SIZE_W-1:0];
    end
  end

  // Slope scale, cells per turn of input phase
  always_ff @(posedge clk) begin
    s_reg <= S_W'(sz) * S_W'(mult_cfg);
  end

  // Outstanding sample count and input stall
  logic             in_acc;
  logic             pop;
  logic             sample_in;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign in_acc    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign sample_in = in_acc && (pcbse_pkg::op_t'(operation) == pcbse_pkg::OP_SAMPLE);
  assign in_stall  = (cnt >= CNT_W'(pcbse_pkg::FIFO_DEPTH));

  always_comb begin
    unique case ({sample_in, pop})
      2'b10:   cnt_next = cnt + CNT_W'(1);
      2'b01:   cnt_next = cnt - CNT_W'(1);
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Pipeline valids
  logic v1, v2, v3;
  logic sv4, sv5, sv6, sv7, sv8, sv9, sv10, sv11;

  // Stage payload registers
  logic               op1, op2, op3;
  logic [9:0]         idx1, idx2, idx3;
  logic [31:0]        val1, val2, val3;
  logic [31:0]        ph1;
  logic [31:0]        red2;
  logic [ADDR_W-1:0]  cell3;
  logic [FRAC_BITS-1:0] frac3;
  logic [WB-1:0]      uu4, u2_4;
  logic [WB:0]        vv4, v2_4;
  logic [WB-1:0]      uu5, u2_5, u3_5;
  logic [WB:0]        v2_5, v3_5;
  logic [31:0]        c5 [4];
  logic signed [31:0] c6 [4];
  logic signed [31:0] w6 [4];
  logic signed [31:0] d6 [4];
  logic signed [63:0] pw7 [4];
  logic signed [63:0] pd7 [4];
  logic signed [63:0] acc_a8, acc_b8, accd_a8, accd_b8;
  logic [35:0]        tq9;
  logic signed [63:0] accd9;
  logic [17:0]        qh10, lo10;
  logic [1:0]         rh10;
  logic signed [PH_W-1:0] phs10;
  logic [PL_W-1:0]    pls10;
  logic [35:0]        q11;
  logic signed [SL_W-1:0] slope11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      sv4 <= 1'b0; sv5 <= 1'b0; sv6 <= 1'b0; sv7 <= 1'b0;
      sv8 <= 1'b0; sv9 <= 1'b0; sv10 <= 1'b0; sv11 <= 1'b0;
    end else begin
      v1   <= in_acc;
      v2   <= v1;
      v3   <= v2;
      sv4  <= v3 && (pcbse_pkg::op_t'(op3) == pcbse_pkg::OP_SAMPLE);
      sv5  <= sv4;
      sv6  <= sv5;
      sv7  <= sv6;
      sv8  <= sv7;
      sv9  <= sv8;
      sv10 <= sv9;
      sv11 <= sv10;
    end
  end

  // Stage 1: capture the input word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op1  <= operation;
      idx1 <= entry_index;
      val1 <= entry_value;
      ph1  <= phase;
    end
  end

  // Stage 2: apply the phase multiplier modulo one turn
  logic [39:0] red_c;
  assign red_c = 40'(ph1) * 40'(mult_cfg);

  always_ff @(posedge clk) begin
    op2  <= op1;
    idx2 <= idx1;
    val2 <= val1;
    red2 <= red_c[31:0];
  end

  // Stage 3: scale into cell and fraction
  logic [32+SIZE_W-1:0] prod_c;
  assign prod_c = (32 + SIZE_W)'(red2) * (32 + SIZE_W)'(sz);

  always_ff @(posedge clk) begin
    op3   <= op2;
    idx3  <= idx2;
    val3  <= val2;
    cell3 <= prod_c[32 +: ADDR_W];
    frac3 <= prod_c[31 -: FRAC_BITS];
  end

  // Neighbour addresses, wrapped over the period
  logic [IW-1:0]     c_e, sz_e, a0, n1, a2, n2, a3;
  logic [ADDR_W-1:0] rd_addr [4];
  logic [31:0]       rd_data [4];
  logic [LW-1:0]     idx_l;
  logic              wr_en;

  always_comb begin
    c_e  = IW'(cell3);
    sz_e = IW'(sz);
    a0   = (cell3 == '0) ? sz_e - IW'(1) : c_e - IW'(1);
    n1   = c_e + IW'(1);
    a2   = (n1 >= sz_e) ? n1 - sz_e : n1;
    n2   = c_e + IW'(2);
    a3   = (n2 >= sz_e) ? n2 - sz_e : n2;
    rd_addr[0] = a0[ADDR_W-1:0];
    rd_addr[1] = cell3;
    rd_addr[2] = a2[ADDR_W-1:0];
    rd_addr[3] = a3[ADDR_W-1:0];
  end

  // Drop loads beyond the table
  assign idx_l = LW'(idx3);
  assign wr_en = v3 && (pcbse_pkg::op_t'(op3) == pcbse_pkg::OP_LOAD) &&
                 (idx_l < LW'(MAX_COEFFS));

  pcbse_coef_mem #(
    .DEPTH  (MAX_COEFFS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_l[ADDR_W-1:0]),
    .wr_data (val3),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage 4: fraction, its complement and their squares
  logic [WB-1:0]   uu_c;
  logic [WB:0]     vv_c;
  logic [2*WB-1:0] u2p_c;
  logic [2*WB+1:0] v2p_c;

  always_comb begin
    uu_c  = WB'(frac3) << (WB - FRAC_BITS);
    vv_c  = ((WB + 1)'(1) << WB) - (WB + 1)'(uu_c);
    u2p_c = (2 * WB)'(uu_c) * (2 * WB)'(uu_c);
    v2p_c = (2 * WB + 2)'(vv_c) * (2 * WB + 2)'(vv_c);
  end

  always_ff @(posedge clk) begin
    uu4  <= uu_c;
    vv4  <= vv_c;
    u2_4 <= u2p_c[2*WB-1:WB];
    v2_4 <= v2p_c[2*WB:WB];
  end

  // Stage 5: cubes
  logic [2*WB-1:0] u3p_c;
  logic [2*WB+1:0] v3p_c;
  assign u3p_c = (2 * WB)'(u2_4) * (2 * WB)'(uu4);
  assign v3p_c = (2 * WB + 2)'(v2_4) * (2 * WB + 2)'(vv4);

  always_ff @(posedge clk) begin
    uu5  <= uu4;
    u2_5 <= u2_4;
    u3_5 <= u3p_c[2*WB-1:WB];
    v2_5 <= v2_4;
    v3_5 <= v3p_c[2*WB:WB];
    for (int k = 0; k < 4; k++) begin
      c5[k] <= rd_data[k];
    end
  end

  // Stage 6: basis weights and their derivatives, six and two times scaled
  logic signed [33:0] eu, eu2, eu3, ev2, ev3, one;
  logic signed [33:0] w_c [4];
  logic signed [33:0] d_c [4];

  always_comb begin
    one = 34'sd1 <<< WB;
    eu  = $signed(34'(uu5));
    eu2 = $signed(34'(u2_5));
    eu3 = $signed(34'(u3_5));
    ev2 = $signed(34'(v2_5));
    ev3 = $signed(34'(v3_5));
    w_c[0] = ev3;
    w_c[1] = 34'sd3 * eu3 - 34'sd6 * eu2 + 34'sd4 * one;
    w_c[2] = -34'sd3 * eu3 + 34'sd3 * eu2 + 34'sd3 * eu + one;
    w_c[3] = eu3;
    d_c[0] = -ev2;
    d_c[1] = 34'sd3 * eu2 - 34'sd4 * eu;
    d_c[2] = -34'sd3 * eu2 + 34'sd2 * eu + one;
    d_c[3] = eu2;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      c6[k] <= $signed(c5[k]);
      w6[k] <= w_c[k][31:0];
      d6[k] <= d_c[k][31:0];
    end
  end

  // Stage 7: weight the four coefficients
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pw7[k] <= c6[k] * w6[k];
      pd7[k] <= c6[k] * d6[k];
    end
  end

  // Stage 8: pairwise sums
  always_ff @(posedge clk) begin
    acc_a8  <= pw7[0] + pw7[1];
    acc_b8  <= pw7[2] + pw7[3];
    accd_a8 <= pd7[0] + pd7[1];
    accd_b8 <= pd7[2] + pd7[3];
  end

  // Stage 9: final sums; offset the value sum so it stays non-negative
  logic [63:0] vsum_c;
  assign vsum_c = 64'(acc_a8) + 64'(acc_b8) + ACC_OFS;

  always_ff @(posedge clk) begin
    tq9   <= {1'b0, vsum_c[63:29]};
    accd9 <= accd_a8 + accd_b8;
  end

  // Stage 10: upper digit of the divide by three; slope partial products
  logic [17:0]            qh_c;
  logic [19:0]            rem_c;
  logic signed [HI_W-1:0] hi_c;
  logic [28:0]            lo_c;

  always_comb begin
    qh_c  = pcbse_pkg::div3_18(tq9[35:18]);
    rem_c = 20'(tq9[35:18]) - 20'(qh_c) * 20'd3;
    hi_c  = accd9[62:29];
    lo_c  = accd9[28:0];
  end

  always_ff @(posedge clk) begin
    qh10  <= qh_c;
    rh10  <= rem_c[1:0];
    lo10  <= tq9[17:0];
    phs10 <= hi_c * $signed({1'b0, s_reg});
    pls10 <= PL_W'(lo_c) * PL_W'(s_reg);
  end

  // Stage 11: lower digit of the divide; round and add the slope parts
  logic [17:0]            q2_c;
  logic [PL_W:0]          rsum_c;
  logic signed [SL_W-1:0] phs_ext;
  logic signed [SL_W-1:0] rnd_ext;

  always_comb begin
    q2_c    = pcbse_pkg::div3_20({rh10, lo10});
    rsum_c  = (PL_W + 1)'(pls10) + ((PL_W + 1)'(1) << 28);
    phs_ext = phs10;
    rnd_ext = $signed(SL_W'(rsum_c[PL_W:29]));
  end

  always_ff @(posedge clk) begin
    q11     <= {qh10, q2_c};
    slope11 <= phs_ext + rnd_ext;
  end

  // Remove the offset and saturate both results
  logic signed [36:0]    vs_c;
  pcbse_pkg::result_t    res_c;
  pcbse_pkg::result_t    rdata;

  always_comb begin
    vs_c = $signed({1'b0, q11}) - V_OFS;
    if (vs_c > V_MAX) begin
      res_c.value = V_MAX[31:0];
    end else if (vs_c < V_MIN) begin
      res_c.value = V_MIN[31:0];
    end else begin
      res_c.value = vs_c[31:0];
    end
    if (slope11 > SL_MAX) begin
      res_c.slope = SL_MAX[47:0];
    end else if (slope11 < SL_MIN) begin
      res_c.slope = SL_MIN[47:0];
    end else begin
      res_c.slope = slope11[47:0];
    end
  end

  pcbse_out_fifo #(
    .DEPTH (pcbse_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (sv11),
    .wdata (res_c),
    .valid (out_valid),
    .stall (out_stall),
    .rdata (rdata)
  );

  assign spline_value = rdata.value;
  assign spline_slope = rdata.slope;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(pcbse_pkg::FIFO_DEPTH))
    else $error("outstanding sample count out of range");
  a_last_counted: assert property (@(posedge clk) disable iff (rst)
    sv11 |-> (cnt != '0))
    else $error("sample in flight not counted");
  a_out_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cnt != '0))
    else $error("word shown with no sample outstanding");
`endif

endmodule
